@@ src/mef_pkg.sv @@
// ----------------------------------------------------------------------------
// mef_pkg: shared types and constants of the median and average distance filter
// Window size, sample width, cell control group and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package mef_pkg;

    localparam int WINDOW      = 7;
    localparam int SAMPLE_BITS = 16;
    localparam int CNT_BITS    = $clog2(WINDOW + 1);
    localparam int STEP_BITS   = $clog2(WINDOW);
    localparam int K_LO        = (WINDOW - 1) / 2;
    localparam int K_HI        = WINDOW / 2;

    typedef logic [SAMPLE_BITS-1:0] t_sample;
    typedef logic [CNT_BITS-1:0]    t_count;
    typedef logic [STEP_BITS-1:0]   t_step;

    typedef struct packed {
        logic shift;
        logic load;
        logic count;
    } t_cell_ctrl;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_SCAN,
        S_SELECT,
        S_FINISH
    } t_state;

endpackage

`default_nettype wire

@@ src/mef_cell.sv @@
// ----------------------------------------------------------------------------
// mef_cell: one window cell of the rank counting chain
// Holds one sample, passes it along the shift row, and counts how many
// circulating probe values lie below and at or below it.
// ----------------------------------------------------------------------------
`default_nettype none

module mef_cell (
    input  wire                       i_clk,
    input  wire mef_pkg::t_cell_ctrl  i_ctrl,
    input  wire mef_pkg::t_sample     i_shift_in,
    input  wire mef_pkg::t_sample     i_probe_in,
    output mef_pkg::t_sample          o_value,
    output mef_pkg::t_sample          o_probe,
    output mef_pkg::t_count           o_lt,
    output mef_pkg::t_count           o_le
);

    mef_pkg::t_sample r_value;
    mef_pkg::t_sample r_probe;
    mef_pkg::t_count  r_lt;
    mef_pkg::t_count  r_le;
    mef_pkg::t_sample n_value;
    mef_pkg::t_sample n_probe;
    mef_pkg::t_count  n_lt;
    mef_pkg::t_count  n_le;

    always_comb begin
        n_value = r_value;
        n_probe = r_probe;
        n_lt    = r_lt;
        n_le    = r_le;
        if (i_ctrl.shift) begin
            n_value = i_shift_in;
        end
        if (i_ctrl.load) begin
            n_probe = r_value;
            n_lt    = '0;
            n_le    = '0;
        end else if (i_ctrl.count) begin
            n_probe = i_probe_in;
            if (r_probe < r_value) begin
                n_lt = r_lt + mef_pkg::t_count'(1);
            end
            if (r_probe <= r_value) begin
                n_le = r_le + mef_pkg::t_count'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_probe <= n_probe;
        r_lt    <= n_lt;
        r_le    <= n_le;
    end

    assign o_value = r_value;
    assign o_probe = r_probe;
    assign o_lt    = r_lt;
    assign o_le    = r_le;

endmodule

`default_nettype wire

@@ src/median_ema_distance_filter.sv @@
// ----------------------------------------------------------------------------
// median_ema_distance_filter: sliding median followed by a halving average
// A row of cells holds the last WINDOW samples; ranks are found by rotating
// probe copies through the row, then the median (the raw sample while the window fills) feeds the moving average.
// ----------------------------------------------------------------------------
// sequence: a request goes straight to FINISH while the window fills, and
//   through LOAD, WINDOW probe rotation steps in SCAN, SELECT and FINISH once full
// handshake: one request at a time; next taken once the result is registered,
//   and FINISH holds while the output is stalled
// reset: synchronous active low; clears fill count, average and handshakes
`default_nettype none

module median_ema_distance_filter (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_valid,
    output logic                                o_ready,
    input  wire  [mef_pkg::SAMPLE_BITS-1:0]     i_sample,
    output logic                                o_valid,
    input  wire                                 i_ready,
    output logic [mef_pkg::SAMPLE_BITS-1:0]     o_filtered,
    output logic                                o_window_full
);

    localparam mef_pkg::t_count WIN_CNT   = mef_pkg::t_count'(mef_pkg::WINDOW);
    localparam mef_pkg::t_count KLO_CNT   = mef_pkg::t_count'(mef_pkg::K_LO);
    localparam mef_pkg::t_count KHI_CNT   = mef_pkg::t_count'(mef_pkg::K_HI);
    localparam mef_pkg::t_step  STEP_LAST = mef_pkg::t_step'(mef_pkg::WINDOW - 1);

    mef_pkg::t_state     r_state;
    mef_pkg::t_state     n_state;
    mef_pkg::t_count     r_fill;
    mef_pkg::t_count     n_fill;
    mef_pkg::t_step      r_step;
    mef_pkg::t_step      n_step;
    mef_pkg::t_sample    r_med;
    mef_pkg::t_sample    n_med;
    logic                r_full;
    logic                n_full;
    mef_pkg::t_sample    r_avg;
    mef_pkg::t_sample    n_avg;
    logic                r_seeded;
    logic                n_seeded;
    logic                r_out_valid;
    logic                n_out_valid;
    mef_pkg::t_sample    r_out;
    mef_pkg::t_sample    n_out;
    logic                r_out_full;
    logic                n_out_full;
    mef_pkg::t_cell_ctrl ctrl;

    mef_pkg::t_sample value [mef_pkg::WINDOW];
    mef_pkg::t_sample probe [mef_pkg::WINDOW];
    mef_pkg::t_count  lt    [mef_pkg::WINDOW];
    mef_pkg::t_count  le    [mef_pkg::WINDOW];

    mef_pkg::t_sample sel_lo;
    mef_pkg::t_sample sel_hi;
    logic [mef_pkg::SAMPLE_BITS:0] med_sum;
    logic [mef_pkg::SAMPLE_BITS:0] avg_sum;
    mef_pkg::t_count  fill_inc;

    genvar g;
    generate
        for (g = 0; g < mef_pkg::WINDOW; g++) begin : g_cell
            mef_cell u_cell (
                .i_clk      (i_clk),
                .i_ctrl     (ctrl),
                .i_shift_in ((g == 0) ? i_sample : value[(g + mef_pkg::WINDOW - 1)
                                                         % mef_pkg::WINDOW]),
                .i_probe_in (probe[(g + mef_pkg::WINDOW - 1) % mef_pkg::WINDOW]),
                .o_value    (value[g]),
                .o_probe    (probe[g]),
                .o_lt       (lt[g]),
                .o_le       (le[g])
            );
        end
    endgenerate

    // rank selection of the middle element(s)
    always_comb begin
        sel_lo = '0;
        sel_hi = '0;
        for (int i = 0; i < mef_pkg::WINDOW; i++) begin
            if (lt[i] <= KLO_CNT && le[i] > KLO_CNT) begin
                sel_lo = sel_lo | value[i];
            end
            if (lt[i] <= KHI_CNT && le[i] > KHI_CNT) begin
                sel_hi = sel_hi | value[i];
            end
        end
        med_sum = {1'b0, sel_lo} + {1'b0, sel_hi};
        avg_sum = {1'b0, r_med} + {1'b0, r_avg};
        fill_inc = (r_fill < WIN_CNT) ? r_fill + mef_pkg::t_count'(1) : r_fill;
    end

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_step      = r_step;
        n_med       = r_med;
        n_full      = r_full;
        n_avg       = r_avg;
        n_seeded    = r_seeded;
        n_out       = r_out;
        n_out_full  = r_out_full;
        n_out_valid = r_out_valid;
        ctrl        = '0;
        o_ready     = 1'b0;
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            mef_pkg::S_IDLE: begin
                o_ready = i_rst_n;
                if (i_valid && i_rst_n) begin
                    ctrl.shift = 1'b1;
                    n_fill     = fill_inc;
                    n_full     = (fill_inc >= WIN_CNT);
                    n_med      = i_sample;
                    n_state    = (fill_inc >= WIN_CNT) ? mef_pkg::S_LOAD
                                                       : mef_pkg::S_FINISH;
                end
            end
            mef_pkg::S_LOAD: begin
                ctrl.load = 1'b1;
                n_step    = '0;
                n_state   = mef_pkg::S_SCAN;
            end
            mef_pkg::S_SCAN: begin
                ctrl.count = 1'b1;
                n_step     = r_step + mef_pkg::t_step'(1);
                if (r_step == STEP_LAST) begin
                    n_state = mef_pkg::S_SELECT;
                end
            end
            mef_pkg::S_SELECT: begin
                n_med   = med_sum[mef_pkg::SAMPLE_BITS:1];
                n_state = mef_pkg::S_FINISH;
            end
            mef_pkg::S_FINISH: begin
                if (!r_out_valid || i_ready) begin
                    if (r_seeded) begin
                        n_avg = avg_sum[mef_pkg::SAMPLE_BITS:1];
                        n_out = avg_sum[mef_pkg::SAMPLE_BITS:1];
                    end else begin
                        n_avg = r_med;
                        n_out = r_med;
                    end
                    n_seeded    = 1'b1;
                    n_out_full  = r_full;
                    n_out_valid = 1'b1;
                    n_state     = mef_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mef_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mef_pkg::S_IDLE;
            r_fill      <= '0;
            r_step      <= '0;
            r_avg       <= '0;
            r_seeded    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_step      <= n_step;
            r_avg       <= n_avg;
            r_seeded    <= n_seeded;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_med      <= n_med;
        r_full     <= n_full;
        r_out      <= n_out;
        r_out_full <= n_out_full;
    end

    assign o_valid       = r_out_valid;
    assign o_filtered    = r_out;
    assign o_window_full = r_out_full;

endmodule

`default_nettype wire

@@ tb/tb_median_ema_distance_filter.sv @@
// ----------------------------------------------------------------------------
// tb_median_ema_distance_filter: self-checking bench for the distance filter
// Drives distance samples through the request handshake, predicts the median
// and halving average for each one, and compares every result in order.
// Random stalls on both sides, a long output hold-off and a full drain pause.
// ----------------------------------------------------------------------------

module tb_median_ema_distance_filter;

    localparam int N_RANDOM    = 1580;
    localparam int LONG_HOLD   = 200;
    localparam int STALL_LIMIT = 2000;
    localparam int N_DIRECTED  = 20;

    typedef struct packed {
        mef_pkg::t_sample filtered;
        logic             window_full;
    } t_result;

    typedef struct packed {
        mef_pkg::t_sample sample;
        logic             typed;
        mef_pkg::t_sample filtered;
        logic             window_full;
    } t_directed_row;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_valid;
    logic             o_ready;
    mef_pkg::t_sample i_sample;
    logic             o_valid;
    logic             i_ready;
    mef_pkg::t_sample o_filtered;
    logic             o_window_full;

    mef_pkg::t_sample win_samples [mef_pkg::WINDOW];
    mef_pkg::t_step   win_slot;
    mef_pkg::t_count  seen_count;
    mef_pkg::t_sample avg_value;
    logic             avg_seeded;

    t_result pending_results [$];
    int      fail_count;
    int      quiet_cycles;
    bit      idle_on;
    bit      hold_out_req;

    t_directed_row directed_rows [N_DIRECTED] = '{
        '{16'hffff, 1'b1, 16'hffff, 1'b0},
        '{16'h0000, 1'b1, 16'h7fff, 1'b0},
        '{16'h0001, 1'b0, 16'h0000, 1'b0},
        '{16'h8000, 1'b0, 16'h0000, 1'b0},
        '{16'h7fff, 1'b0, 16'h0000, 1'b0},
        '{16'haaaa, 1'b0, 16'h0000, 1'b0},
        '{16'h5555, 1'b0, 16'h0000, 1'b0},
        '{16'hffff, 1'b0, 16'h0000, 1'b0},
        '{16'hffff, 1'b0, 16'h0000, 1'b0},
        '{16'hffff, 1'b0, 16'h0000, 1'b0},
        '{16'hffff, 1'b0, 16'h0000, 1'b0},
        '{16'h0000, 1'b0, 16'h0000, 1'b0},
        '{16'h0000, 1'b0, 16'h0000, 1'b0},
        '{16'h0000, 1'b0, 16'h0000, 1'b0},
        '{16'h0000, 1'b0, 16'h0000, 1'b0},
        '{16'h1234, 1'b0, 16'h0000, 1'b0},
        '{16'h1234, 1'b0, 16'h0000, 1'b0},
        '{16'h1234, 1'b0, 16'h0000, 1'b0},
        '{16'h8001, 1'b0, 16'h0000, 1'b0},
        '{16'hfffe, 1'b0, 16'h0000, 1'b0}
    };

    median_ema_distance_filter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_sample      (i_sample),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_filtered    (o_filtered),
        .o_window_full (o_window_full)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic t_result predict_filter(input mef_pkg::t_sample s);
        mef_pkg::t_sample              sorted [mef_pkg::WINDOW];
        mef_pkg::t_sample              key;
        mef_pkg::t_sample              med;
        logic [mef_pkg::SAMPLE_BITS:0] sum;
        int                            j;
        t_result                       r;
        win_samples[win_slot] = s;
        win_slot = (win_slot == mef_pkg::WINDOW - 1) ? '0 : win_slot + 1'b1;
        if (seen_count < mef_pkg::WINDOW) seen_count = seen_count + 1'b1;
        r.window_full = (seen_count == mef_pkg::WINDOW);
        if (r.window_full) begin
            sorted = win_samples;
            for (int i = 1; i < mef_pkg::WINDOW; i++) begin
                key = sorted[i];
                j = i - 1;
                while (j >= 0 && sorted[j] > key) begin
                    sorted[j + 1] = sorted[j];
                    j--;
                end
                sorted[j + 1] = key;
            end
            sum = {1'b0, sorted[mef_pkg::K_LO]} + {1'b0, sorted[mef_pkg::K_HI]};
            med = sum[mef_pkg::SAMPLE_BITS:1];
        end else begin
            med = s;
        end
        if (!avg_seeded) begin
            avg_value  = med;
            avg_seeded = 1'b1;
        end else begin
            sum = {1'b0, med} + {1'b0, avg_value};
            avg_value = sum[mef_pkg::SAMPLE_BITS:1];
        end
        r.filtered = avg_value;
        return r;
    endfunction

    function automatic mef_pkg::t_sample pick_sample(input mef_pkg::t_sample prev);
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3, 4: return mef_pkg::t_sample'(prev + $urandom_range(0, 31) - 16);
            5:       return mef_pkg::t_sample'($urandom_range(0, 255));
            6:       return prev;
            default: return mef_pkg::t_sample'($urandom);
        endcase
    endfunction

    task automatic offer_request(input mef_pkg::t_sample s, input bit typed,
                                 input t_result typed_res);
        t_result r;
        i_valid  <= 1'b1;
        i_sample <= s;
        do @(posedge i_clk); while (!o_ready);
        r = predict_filter(s);
        if (typed) r = typed_res;
        pending_results.push_back(r);
        @(negedge i_clk);
    endtask

    // sender
    initial begin
        mef_pkg::t_sample smp;
        t_result          typed_res;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_sample     = '0;
        idle_on      = 1'b0;
        hold_out_req = 1'b0;
        fail_count   = 0;
        win_samples  = '{default: '0};
        win_slot     = '0;
        seen_count   = '0;
        avg_value    = '0;
        avg_seeded   = 1'b0;
        smp          = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[k]) begin
            typed_res.filtered    = directed_rows[k].filtered;
            typed_res.window_full = directed_rows[k].window_full;
            offer_request(directed_rows[k].sample, directed_rows[k].typed, typed_res);
        end

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % 100 == 0)
                idle_on = (n < N_RANDOM - 200) && ($urandom_range(0, 3) != 0);
            if (n == 300)
                hold_out_req = 1'b1;
            if (n == 700) begin
                i_valid <= 1'b0;
                @(negedge i_clk);
                while (pending_results.size() != 0) @(negedge i_clk);
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 11)) @(negedge i_clk);
            end
            smp = pick_sample(smp);
            offer_request(smp, 1'b0, '0);
        end
        i_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4 * (mef_pkg::WINDOW + 4)) @(posedge i_clk);
        if (fail_count == 0)
            $display("tb_median_ema_distance_filter: PASS");
        else
            $display("tb_median_ema_distance_filter: FAIL");
        $finish;
    end

    // receiver
    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_out_req) begin
                i_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
                hold_out_req = 1'b0;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 11) - 1) @(negedge i_clk);
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: filtered=%h window_full=%b",
                       o_filtered, o_window_full);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_filtered !== want.filtered) begin
                    $error("filtered: expected %h, got %h", want.filtered, o_filtered);
                    fail_count++;
                end
                if (o_window_full !== want.window_full) begin
                    $error("window_full: expected %b, got %b",
                           want.window_full, o_window_full);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        quiet_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("tb_median_ema_distance_filter: FAIL");
                $finish;
            end
        end
    end

endmodule
